// ===== rtl/core/dcsb_pkg.sv =====
// Shared constants, operation codes and compare result type of the basis table.
`default_nettype none

package dcsb_pkg;

  localparam int TABLE_CAPACITY_DEF = 1024;
  localparam int COORD_BITS_DEF     = 10;
  localparam int OP_W               = 3;
  localparam int DIMS_W             = 2;

  localparam logic [DIMS_W-1:0] DIMS_THREE = 2'd3;
  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_THREE;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_QUERY  = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef struct packed {
    logic dom;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcsb_in_if.sv =====
// Request channel of the basis table: one operation and its point per beat.
`default_nettype none

interface dcsb_in_if #(
  parameter int COORD_BITS = dcsb_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = $clog2(dcsb_pkg::TABLE_CAPACITY_DEF)
);
  logic                       valid;
  logic                       ready;
  logic [dcsb_pkg::OP_W-1:0]  operation;
  logic [COORD_BITS-1:0]      coord_first;
  logic [COORD_BITS-1:0]      coord_second;
  logic [COORD_BITS-1:0]      coord_third;
  logic                       point_invalid;
  logic [IDX_W-1:0]           position;

  modport source (
    output valid, operation, coord_first, coord_second, coord_third,
           point_invalid, position,
    input  ready
  );

  modport sink (
    input  valid, operation, coord_first, coord_second, coord_third,
           point_invalid, position,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/dcsb_out_if.sv =====
// Response channel of the basis table: one result per beat.
`default_nettype none

interface dcsb_out_if #(
  parameter int COORD_BITS = dcsb_pkg::COORD_BITS_DEF,
  parameter int CNT_W      = $clog2(dcsb_pkg::TABLE_CAPACITY_DEF + 1)
);
  logic                  valid;
  logic                  ready;
  logic                  inside_res;
  logic                  changed;
  logic                  overflow;
  logic [CNT_W-1:0]      entry_count;
  logic                  read_valid;
  logic [COORD_BITS-1:0] read_first;
  logic [COORD_BITS-1:0] read_second;
  logic [COORD_BITS-1:0] read_third;

  modport source (
    output valid, inside_res, changed, overflow, entry_count, read_valid,
           read_first, read_second, read_third,
    input  ready
  );

  modport sink (
    input  valid, inside_res, changed, overflow, entry_count, read_valid,
           read_first, read_second, read_third,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/downward_closed_set_basis_table.sv =====
// Top level of the basis table: operation sequencer around the point memory.
`default_nettype none

// Holds up to TABLE_CAPACITY basis points of a downward-closed grid set in one
// synchronous memory and handles one operation at a time, scanning the stored
// entries through the memory's single read port at one entry per cycle. Remove
// finds the match, shifts the entries behind it down, then for each lowered
// point picks the coordinate, scans the entries then stored for one that
// dominates it and appends it if none does. The memory is not cleared after
// reset; only entries below the count are ever used. A new request is taken
// as soon as the previous result has been handed to the output register,
// even if that result still waits there. dims is written through cfg_we /
// cfg_wdata and resets to three.
module downward_closed_set_basis_table #(
  parameter int TABLE_CAPACITY = dcsb_pkg::TABLE_CAPACITY_DEF,
  parameter int COORD_BITS     = dcsb_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dcsb_pkg::DIMS_W-1:0]   cfg_wdata,
  dcsb_in_if.sink                       req,
  dcsb_out_if.source                    rsp
);
  import dcsb_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_CAPACITY);
  localparam int CNT_W   = $clog2(TABLE_CAPACITY + 1);
  localparam int ENTRY_W = 3 * COORD_BITS;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_SHIFT   = 7'b0000100,
    S_APPEND  = 7'b0001000,
    S_NEXTDIM = 7'b0010000,
    S_READ    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t              state;
  logic [OP_W-1:0]     op;
  logic [DIMS_W-1:0]   dims;
  logic [ENTRY_W-1:0]  pt;
  logic [ENTRY_W-1:0]  cand;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    scan_addr;
  logic                chk_pend;
  logic [IDX_W-1:0]    chk_addr;
  logic                match_mode;
  logic [1:0]          dim;

  logic                inside_w;
  logic                changed_w;
  logic                ovf_w;
  logic                rvalid_w;
  logic [ENTRY_W-1:0]  rdata_w;

  logic                out_valid;
  logic                out_inside;
  logic                out_changed;
  logic                out_ovf;
  logic [CNT_W-1:0]    out_count;
  logic                out_rvalid;
  logic [ENTRY_W-1:0]  out_data;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;

  cmp_t                cmp;
  logic                three;
  logic                full;
  logic                issue;
  logic                hit;
  logic                dim_done;
  logic [COORD_BITS-1:0] sel_coord;
  logic [ENTRY_W-1:0]  cand_next;
  logic                out_free;

  dcsb_ram #(
    .DEPTH  (TABLE_CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dcsb_point_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cmp (
    .entry  (mem_rdata),
    .point  (cand),
    .three  (three),
    .result (cmp)
  );

  assign three    = (dims == DIMS_THREE);
  assign full     = (count == CNT_W'(TABLE_CAPACITY));
  assign issue    = (scan_addr < count);
  assign hit      = chk_pend && (match_mode ? cmp.eq : cmp.dom);
  assign dim_done = (dim == 2'd3) || ((dim == 2'd2) && !three);
  assign out_free = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);

  always_comb begin
    case (dim)
      2'd0:    sel_coord = pt[0 +: COORD_BITS];
      2'd1:    sel_coord = pt[COORD_BITS +: COORD_BITS];
      default: sel_coord = pt[2*COORD_BITS +: COORD_BITS];
    endcase
    cand_next = pt;
    case (dim)
      2'd0:    cand_next[0 +: COORD_BITS]            = sel_coord - COORD_BITS'(1);
      2'd1:    cand_next[COORD_BITS +: COORD_BITS]   = sel_coord - COORD_BITS'(1);
      default: cand_next[2*COORD_BITS +: COORD_BITS] = sel_coord - COORD_BITS'(1);
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_addr - IDX_W'(1);
    mem_wdata = mem_rdata;
    mem_raddr = scan_addr[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        mem_raddr = req.position;
      end
      S_SHIFT: begin
        // move the entry read last cycle one place down
        mem_we = chk_pend;
      end
      S_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = count[IDX_W-1:0];
        mem_wdata = cand;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= DIMS_RESET;
    end else if (cfg_we) begin
      dims <= cfg_wdata;
    end
  end

  // load a finished result, drop the one that leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.operation;
            pt         <= {three ? req.coord_third : COORD_BITS'(0),
                           req.coord_second, req.coord_first};
            cand       <= {three ? req.coord_third : COORD_BITS'(0),
                           req.coord_second, req.coord_first};
            inside_w   <= 1'b0;
            changed_w  <= 1'b0;
            ovf_w      <= 1'b0;
            rvalid_w   <= (req.operation == OP_READ) && (CNT_W'(req.position) < count);
            rdata_w    <= '0;
            scan_addr  <= '0;
            chk_pend   <= 1'b0;
            match_mode <= (req.operation == OP_REMOVE);
            case (req.operation)
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              OP_QUERY, OP_ADD, OP_REMOVE: begin
                state <= req.point_invalid ? S_DONE : S_SCAN;
              end
              OP_READ: begin
                if (CNT_W'(req.position) < count) begin
                  state <= S_READ;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            chk_pend <= 1'b0;
            case (op)
              OP_QUERY: begin
                inside_w <= 1'b1;
                state    <= S_DONE;
              end
              OP_REMOVE: begin
                if (match_mode) begin
                  changed_w <= 1'b1;
                  scan_addr <= CNT_W'(chk_addr) + CNT_W'(1);
                  state     <= S_SHIFT;
                end else begin
                  state <= S_NEXTDIM;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end else if (!chk_pend && !issue) begin
            case (op)
              OP_ADD: begin
                if (full) begin
                  ovf_w <= 1'b1;
                  state <= S_DONE;
                end else begin
                  state <= S_APPEND;
                end
              end
              OP_REMOVE: begin
                if (match_mode) begin
                  state <= S_DONE;
                end else if (full) begin
                  ovf_w <= 1'b1;
                  state <= S_NEXTDIM;
                end else begin
                  state <= S_APPEND;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end else begin
            if (issue) begin
              scan_addr <= scan_addr + CNT_W'(1);
              chk_addr  <= scan_addr[IDX_W-1:0];
            end
            chk_pend <= issue;
          end
        end
        S_SHIFT: begin
          if (!chk_pend && !issue) begin
            count <= count - CNT_W'(1);
            dim   <= 2'd0;
            state <= S_NEXTDIM;
          end else begin
            if (issue) begin
              scan_addr <= scan_addr + CNT_W'(1);
              chk_addr  <= scan_addr[IDX_W-1:0];
            end
            chk_pend <= issue;
          end
        end
        S_APPEND: begin
          count <= count + CNT_W'(1);
          if (op == OP_ADD) begin
            changed_w <= 1'b1;
            state     <= S_DONE;
          end else begin
            state <= S_NEXTDIM;
          end
        end
        S_NEXTDIM: begin
          if (dim_done) begin
            state <= S_DONE;
          end else begin
            dim <= dim + 2'd1;
            // lower this coordinate only when it is above one
            if (sel_coord > COORD_BITS'(1)) begin
              cand       <= cand_next;
              scan_addr  <= '0;
              chk_pend   <= 1'b0;
              match_mode <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_READ: begin
          rdata_w <= mem_rdata;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_inside  <= inside_w;
      out_changed <= changed_w;
      out_ovf     <= ovf_w;
      out_count   <= count;
      out_rvalid  <= rvalid_w;
      out_data    <= rdata_w;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.inside_res  = out_inside;
  assign rsp.changed     = out_changed;
  assign rsp.overflow    = out_ovf;
  assign rsp.entry_count = out_count;
  assign rsp.read_valid  = out_rvalid;
  assign rsp.read_first  = out_data[0 +: COORD_BITS];
  assign rsp.read_second = out_data[COORD_BITS +: COORD_BITS];
  assign rsp.read_third  = out_data[2*COORD_BITS +: COORD_BITS];

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.operation == OP_CLEAR |=> count == '0)
    else $error("clear did not empty the table");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_we && state == S_SHIFT |-> mem_waddr != mem_raddr)
    else $error("shift writes the entry it reads");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> out_valid && state == S_IDLE)
    else $error("finished result not loaded into output register");

endmodule

`default_nettype wire

// ===== rtl/core/dcsb_ram.sv =====
// Basis point memory: one write port, one read port with registered read data.
`default_nettype none

module dcsb_ram #(
  parameter int DEPTH  = dcsb_pkg::TABLE_CAPACITY_DEF,
  parameter int ADDR_W = $clog2(dcsb_pkg::TABLE_CAPACITY_DEF),
  parameter int DATA_W = 3 * dcsb_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/dcsb_point_cmp.sv =====
// Compares a stored entry against a point: dominance and exact match.
`default_nettype none

module dcsb_point_cmp #(
  parameter int COORD_BITS = dcsb_pkg::COORD_BITS_DEF
) (
  input  logic [3*COORD_BITS-1:0] entry,
  input  logic [3*COORD_BITS-1:0] point,
  input  logic                    three,
  output dcsb_pkg::cmp_t          result
);
  import dcsb_pkg::*;

  logic [2:0] le;
  logic [2:0] eq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      le[i] = point[i*COORD_BITS +: COORD_BITS] <= entry[i*COORD_BITS +: COORD_BITS];
      eq[i] = point[i*COORD_BITS +: COORD_BITS] == entry[i*COORD_BITS +: COORD_BITS];
    end
    // third coordinate counts only in three-dimension mode
    result.dom = le[0] && le[1] && (le[2] || !three);
    result.eq  = eq[0] && eq[1] && (eq[2] || !three);
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the downward-closed set basis table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcsb_pkg::*;

  localparam int BASIS_CAP = TABLE_CAPACITY_DEF;
  localparam int CW        = COORD_BITS_DEF;
  localparam int IDXW      = $clog2(TABLE_CAPACITY_DEF);
  localparam int CNTW      = $clog2(TABLE_CAPACITY_DEF + 1);

  // Operation codes the block treats as no-ops.
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  // Every dims value other than three selects two dimensions.
  localparam logic [DIMS_W-1:0] DIMS_TWO        = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_TWO_ALT_LO = 2'd0;
  localparam logic [DIMS_W-1:0] DIMS_TWO_ALT_HI = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CW-1:0]   crd1;
    logic [CW-1:0]   crd2;
    logic [CW-1:0]   crd3;
    logic            inv;
    logic [IDXW-1:0] pos;
  } basis_req_t;

  typedef struct packed {
    logic            inside_res;
    logic            changed;
    logic            overflow;
    logic [CNTW-1:0] entry_count;
    logic            read_valid;
    logic [CW-1:0]   read_first;
    logic [CW-1:0]   read_second;
    logic [CW-1:0]   read_third;
  } basis_rsp_t;

  typedef struct {
    bit                set_dims;
    logic [DIMS_W-1:0] dims;
    basis_req_t        rq;
    bit                typed;
    basis_rsp_t        want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [DIMS_W-1:0] cfg_wdata;

  dcsb_in_if  req();
  dcsb_out_if rsp();

  downward_closed_set_basis_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  // Shadow copy of the table and its setting.
  logic [CW-1:0]     shadow_pts [BASIS_CAP][3];
  int                shadow_n;
  logic [DIMS_W-1:0] shadow_dims;

  basis_rsp_t pending_rsp [$];
  dir_row_t   script [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int sent;
  int results_checked;
  int n_inside;
  int n_changed;
  int n_overflow;
  int n_reads;
  int bad_results;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #48_000_000;
    $display("downward_closed_set_basis_table test failed");
    $finish;
  end

  function automatic bit covered_by_table(input logic [CW-1:0] a, b, c);
    bit three;
    three = (shadow_dims == DIMS_THREE);
    for (int k = 0; k < shadow_n; k++) begin
      if (a <= shadow_pts[k][0] && b <= shadow_pts[k][1] &&
          (!three || c <= shadow_pts[k][2]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit table_append(input logic [CW-1:0] a, b, c);
    if (shadow_n >= BASIS_CAP)
      return 1'b0;
    shadow_pts[shadow_n][0] = a;
    shadow_pts[shadow_n][1] = b;
    shadow_pts[shadow_n][2] = c;
    shadow_n++;
    return 1'b1;
  endfunction

  function automatic basis_rsp_t apply_basis_op(input basis_req_t r);
    basis_rsp_t o;
    logic [CW-1:0] pt [3];
    logic [CW-1:0] cand [3];
    bit three;
    int k;
    o = '0;
    three = (shadow_dims == DIMS_THREE);
    pt[0] = r.crd1;
    pt[1] = r.crd2;
    pt[2] = three ? r.crd3 : '0;
    case (r.op)
      OP_CLEAR: shadow_n = 0;
      OP_QUERY: o.inside_res = !r.inv && covered_by_table(pt[0], pt[1], pt[2]);
      OP_ADD: begin
        if (!r.inv && !covered_by_table(pt[0], pt[1], pt[2])) begin
          if (table_append(pt[0], pt[1], pt[2]))
            o.changed = 1'b1;
          else
            o.overflow = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!r.inv) begin
          k = 0;
          while (k < shadow_n && !(shadow_pts[k][0] == pt[0] && shadow_pts[k][1] == pt[1] &&
                                   (!three || shadow_pts[k][2] == pt[2])))
            k++;
          if (k < shadow_n) begin
            o.changed = 1'b1;
            for (int j = k; j + 1 < shadow_n; j++)
              shadow_pts[j] = shadow_pts[j + 1];
            shadow_n--;
            // try each lowered neighbor in coordinate order
            for (int i = 0; i < (three ? 3 : 2); i++) begin
              if (pt[i] > 1) begin
                cand = pt;
                cand[i] = pt[i] - 1'b1;
                if (!covered_by_table(cand[0], cand[1], cand[2])) begin
                  if (!table_append(cand[0], cand[1], cand[2]))
                    o.overflow = 1'b1;
                end
              end
            end
          end
        end
      end
      OP_READ: begin
        if (r.pos < shadow_n) begin
          o.read_valid  = 1'b1;
          o.read_first  = shadow_pts[r.pos][0];
          o.read_second = shadow_pts[r.pos][1];
          o.read_third  = shadow_pts[r.pos][2];
        end
      end
      default: ;
    endcase
    o.entry_count = CNTW'(shadow_n);
    return o;
  endfunction

  function automatic basis_req_t mk(input logic [OP_W-1:0] op, input logic [CW-1:0] a, b, c,
                                    input logic inv, input logic [IDXW-1:0] pos);
    basis_req_t r;
    r.op = op;
    r.crd1 = a;
    r.crd2 = b;
    r.crd3 = c;
    r.inv = inv;
    r.pos = pos;
    return r;
  endfunction

  function automatic basis_rsp_t res(input logic ins, chg, ovf, input logic [CNTW-1:0] cnt,
                                     input logic rv, input logic [CW-1:0] r1, r2, r3);
    basis_rsp_t o;
    o.inside_res = ins;
    o.changed = chg;
    o.overflow = ovf;
    o.entry_count = cnt;
    o.read_valid = rv;
    o.read_first = r1;
    o.read_second = r2;
    o.read_third = r3;
    return o;
  endfunction

  function automatic dir_row_t pred(input logic [OP_W-1:0] op, input logic [CW-1:0] a, b, c,
                                    input logic inv, input logic [IDXW-1:0] pos);
    dir_row_t s;
    s.set_dims = 1'b0;
    s.dims = '0;
    s.rq = mk(op, a, b, c, inv, pos);
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic dir_row_t known(input logic [OP_W-1:0] op, input logic [CW-1:0] a, b, c,
                                     input logic inv, input logic [IDXW-1:0] pos,
                                     input basis_rsp_t w);
    dir_row_t s;
    s = pred(op, a, b, c, inv, pos);
    s.typed = 1'b1;
    s.want = w;
    return s;
  endfunction

  function automatic dir_row_t dims_row(input logic [DIMS_W-1:0] v);
    dir_row_t s;
    s = pred(OP_CLEAR, 0, 0, 0, 0, 0);
    s.set_dims = 1'b1;
    s.dims = v;
    return s;
  endfunction

  function automatic logic [CW-1:0] coord_in(input int span);
    if ($urandom_range(19) == 0)
      return '0;
    return CW'($urandom_range(1, span));
  endfunction

  function automatic logic rare_invalid();
    return ($urandom_range(9) == 0);
  endfunction

  function automatic string show(input basis_rsp_t v);
    return $sformatf("inside=%0d changed=%0d ovf=%0d count=%0d rv=%0d rd=(%0d,%0d,%0d)",
                     v.inside_res, v.changed, v.overflow, v.entry_count, v.read_valid,
                     v.read_first, v.read_second, v.read_third);
  endfunction

  function automatic void note_bad(input string msg);
    bad_results++;
    if (bad_results <= 10)
      $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic push_request(input basis_req_t r, input bit typed, input basis_rsp_t typed_rsp);
    basis_rsp_t model_rsp;
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid         <= 1'b1;
    req.operation     <= r.op;
    req.coord_first   <= r.crd1;
    req.coord_second  <= r.crd2;
    req.coord_third   <= r.crd3;
    req.point_invalid <= r.inv;
    req.position      <= r.pos;
    @(posedge clk);
    while (!req.ready)
      @(posedge clk);
    model_rsp = apply_basis_op(r);
    pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : model_rsp);
    sent++;
    @(negedge clk);
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [CW-1:0] a, b, c,
                       input logic inv, input logic [IDXW-1:0] pos);
    push_request(mk(op, a, b, c, inv, pos), 1'b0, '0);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_dims(input logic [DIMS_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_dims = v;
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int n_items);
    int stop_at;
    int span;
    int k;
    int pick;
    logic [CW-1:0] a, b, c;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        issue(OP_CLEAR, CW'($urandom), CW'($urandom), CW'($urandom), 1'($urandom),
              IDXW'($urandom));
        span = ($urandom_range(4) == 0) ? (1 << CW) - 1 : $urandom_range(3, 12);
        repeat ($urandom_range(2, 9))
          issue(OP_ADD, coord_in(span), coord_in(span), coord_in(span), rare_invalid(),
                IDXW'($urandom));
        repeat ($urandom_range(4, 14)) begin
          pick = $urandom_range(99);
          k = (shadow_n > 0) ? $urandom_range(shadow_n - 1) : 0;
          if (pick < 35 && shadow_n > 0) begin
            c = (shadow_dims == DIMS_THREE) ? shadow_pts[k][2] : coord_in(span);
            issue(OP_REMOVE, shadow_pts[k][0], shadow_pts[k][1], c, rare_invalid(),
                  IDXW'($urandom));
          end else if (pick < 60) begin
            if (shadow_n > 0 && $urandom_range(1)) begin
              a = CW'($urandom_range(shadow_pts[k][0]));
              b = CW'($urandom_range(shadow_pts[k][1]));
              c = CW'($urandom_range(shadow_pts[k][2]));
            end else begin
              a = coord_in(span);
              b = coord_in(span);
              c = coord_in(span);
            end
            issue(OP_QUERY, a, b, c, rare_invalid(), IDXW'($urandom));
          end else if (pick < 75) begin
            issue(OP_READ, CW'($urandom), CW'($urandom), CW'($urandom),
                  1'($urandom_range(1)), IDXW'($urandom_range(shadow_n + 1)));
          end else if (pick < 90) begin
            issue(OP_ADD, coord_in(span), coord_in(span), coord_in(span), rare_invalid(),
                  IDXW'($urandom));
          end else begin
            issue(OP_REMOVE, coord_in(span), coord_in(span), coord_in(span), rare_invalid(),
                  IDXW'($urandom));
          end
        end
      end else begin
        // noise: any code, any field
        repeat ($urandom_range(1, 4))
          issue(OP_W'($urandom_range(7)), CW'($urandom), CW'($urandom), CW'($urandom),
                1'($urandom_range(1)), IDXW'($urandom));
      end
    end
  endtask

  always @(negedge clk)
    rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin
    basis_rsp_t seen;
    basis_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      seen.inside_res  = rsp.inside_res;
      seen.changed     = rsp.changed;
      seen.overflow    = rsp.overflow;
      seen.entry_count = rsp.entry_count;
      seen.read_valid  = rsp.read_valid;
      seen.read_first  = rsp.read_first;
      seen.read_second = rsp.read_second;
      seen.read_third  = rsp.read_third;
      if (pending_rsp.size() == 0) begin
        note_bad($sformatf("result with nothing pending: %s", show(seen)));
      end else begin
        want = pending_rsp.pop_front();
        results_checked++;
        if (seen !== want)
          note_bad($sformatf("expected %s, got %s", show(want), show(seen)));
        n_inside   += seen.inside_res;
        n_changed  += seen.changed;
        n_overflow += seen.overflow;
        n_reads    += seen.read_valid;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.operation = '0;
    req.coord_first = '0;
    req.coord_second = '0;
    req.coord_third = '0;
    req.point_invalid = 1'b0;
    req.position = '0;
    shadow_n = 0;
    shadow_dims = DIMS_RESET;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    sent = 0;
    results_checked = 0;
    n_inside = 0;
    n_changed = 0;
    n_overflow = 0;
    n_reads = 0;
    bad_results = 0;

    script = '{
      known(OP_READ,    1,    1,    1,    0, 0,    res(0, 0, 0, 0, 0, 0, 0, 0)),
      known(OP_QUERY,   1,    1,    1,    0, 0,    res(0, 0, 0, 0, 0, 0, 0, 0)),
      known(OP_RSVD5,   7,    7,    7,    0, 3,    res(0, 0, 0, 0, 0, 0, 0, 0)),
      known(OP_ADD,     1023, 1023, 1023, 0, 0,    res(0, 1, 0, 1, 0, 0, 0, 0)),
      known(OP_QUERY,   1023, 1023, 1023, 0, 0,    res(1, 0, 0, 1, 0, 0, 0, 0)),
      known(OP_QUERY,   1,    1,    1,    1, 0,    res(0, 0, 0, 1, 0, 0, 0, 0)),
      known(OP_ADD,     5,    5,    5,    0, 0,    res(0, 0, 0, 1, 0, 0, 0, 0)),
      known(OP_READ,    1,    1,    1,    0, 0,    res(0, 0, 0, 1, 1, 1023, 1023, 1023)),
      known(OP_READ,    1,    1,    1,    0, 1023, res(0, 0, 0, 1, 0, 0, 0, 0)),
      known(OP_REMOVE,  1023, 1023, 1023, 1, 0,    res(0, 0, 0, 1, 0, 0, 0, 0)),
      pred(OP_REMOVE,   1023, 1023, 1023, 0, 0),
      pred(OP_READ,     0,    0,    0,    0, 2),
      pred(OP_QUERY,    1023, 1023, 1023, 0, 0),
      known(OP_CLEAR,   1023, 1023, 1023, 1, 1023, res(0, 0, 0, 0, 0, 0, 0, 0)),
      pred(OP_ADD,      0,    0,    0,    0, 0),
      pred(OP_ADD,      1,    1,    5,    0, 0),
      pred(OP_REMOVE,   1,    1,    5,    0, 0),
      pred(OP_REMOVE,   0,    0,    0,    0, 0),
      // equal in two dims, distinct in three: remove must take the first only
      pred(OP_ADD,      3,    3,    2,    0, 0),
      pred(OP_ADD,      3,    3,    9,    0, 0),
      dims_row(DIMS_TWO_ALT_LO),
      pred(OP_REMOVE,   3,    3,    7,    0, 0),
      pred(OP_READ,     0,    0,    0,    0, 1),
      pred(OP_ADD,      8,    1,    777,  0, 0),
      pred(OP_READ,     0,    0,    0,    0, 2),
      pred(OP_RSVD6,    2,    2,    2,    0, 0),
      pred(OP_RSVD7,    1023, 1023, 1023, 1, 1023),
      dims_row(DIMS_THREE)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    foreach (script[i]) begin
      if (script[i].set_dims)
        write_dims(script[i].dims);
      else
        push_request(script[i].rq, script[i].typed, script[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_dims(DIMS_THREE);
        1: write_dims(DIMS_TWO);
        2: write_dims(DIMS_TWO_ALT_HI);
        default: write_dims(DIMS_THREE);
      endcase
      case (ph)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 80;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 80;
        end
        default: begin
          sender_idle_pct = 34;
          receiver_stall_pct = 34;
        end
      endcase
      run_random_phase(130);
    end

    wait_drained();
    repeat (300) @(posedge clk);

    $display("Run covered %0d requests: directed cases, then random phases over dims 3/2/1/3",
             sent);
    $display("under four idle mixes; %0d results, %0d inside, %0d changed, %0d overflow,",
             results_checked, n_inside, n_changed, n_overflow);
    $display("%0d reads, %0d errors.", n_reads, bad_results);
    if (bad_results == 0)
      $display("downward_closed_set_basis_table test passed");
    else
      $display("downward_closed_set_basis_table test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dcsb_pkg.sv
rtl/core/dcsb_in_if.sv
rtl/core/dcsb_out_if.sv
rtl/core/dcsb_ram.sv
rtl/core/dcsb_point_cmp.sv
rtl/core/downward_closed_set_basis_table.sv
tb/testbench.sv
